/* sv/cau_pkg.sv */
// Package for the complex arithmetic unit: operation codes, payload structs,
// and shared widths. No dependencies.
package cau_pkg;

   localparam int FIELD_W = 32;
   localparam int PROD_W  = 64;

   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_MAG = 3'd4
   } func_type;

   typedef struct packed {
      logic [2:0]               func;
      logic signed [FIELD_W-1:0] a_re;
      logic signed [FIELD_W-1:0] a_im;
      logic signed [FIELD_W-1:0] b_re;
      logic signed [FIELD_W-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] res_re;
      logic signed [FIELD_W-1:0] res_im;
      logic                      div_by_zero;
      logic                      overflow;
   } rsp_type;

   // Work carried from cell to cell of the divide / square root chain.
   typedef struct packed {
      logic        valid;
      logic [2:0]  func;
      logic        dz;
      logic        neg_re;
      logic        neg_im;
      logic        sat_re;
      logic        sat_im;
      logic [PROD_W-1:0]  rem_re;   // partial remainder / radicand
      logic [PROD_W-1:0]  rem_im;
      logic [PROD_W-1:0]  den;      // divisor |b|^2
      logic [PROD_W-1:0]  q_re;     // quotient or root bits so far
      logic [PROD_W-1:0]  q_im;
      logic signed [FIELD_W-1:0] pre_re;  // finished add/sub/mul values
      logic signed [FIELD_W-1:0] pre_im;
      logic        pre_ovf;
   } lane_type;

endpackage

/* sv/cau_cell.sv */
// One cell of the quotient / root chain: produces one quotient bit for each
// numerator part, or one root bit. Depends on cau_pkg.
module cau_cell import cau_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  lane_type lane_in,
   output lane_type lane_out
);

   localparam int TOTAL = 96;
   localparam int ISHIFT = (STEP < PROD_W) ? PROD_W - 1 - STEP : 0;

   // Restoring divide of num * 2^32 by den, one quotient bit per cell. The
   // first 64 cells compare the remainder against den shifted up to the bit's
   // weight; the last 32 cells shift the remainder left and compare with den.
   function automatic logic [PROD_W:0] div_step(input logic [PROD_W-1:0] rem,
                                                input logic [PROD_W-1:0] den);
      logic [2*PROD_W-1:0] d;
      logic [PROD_W:0]     r2;
      logic                take;
      logic [PROD_W-1:0]   nxt;
      d = '0;
      r2 = '0;
      if (STEP < PROD_W) begin
         d = {{PROD_W{1'b0}}, den} << ISHIFT;
         take = {{PROD_W{1'b0}}, rem} >= d;
         nxt = take ? rem - d[PROD_W-1:0] : rem;
      end else begin
         r2 = {rem, 1'b0};
         take = r2 >= {1'b0, den};
         nxt = take ? PROD_W'(r2 - {1'b0, den}) : r2[PROD_W-1:0];
      end
      div_step = {take, nxt};
   endfunction

   lane_type lane_ff, lane_in_c;
   logic [PROD_W:0] sr, si;
   logic [PROD_W-1:0] trial;
   logic [PROD_W-1:0] bitv;

   always_comb begin
      lane_in_c = lane_in;
      sr = '0;
      si = '0;
      trial = '0;
      bitv = '0;
      if (lane_in.func == FUNC_DIV) begin
         sr = div_step(lane_in.rem_re, lane_in.den);
         si = div_step(lane_in.rem_im, lane_in.den);
         lane_in_c.rem_re = sr[PROD_W-1:0];
         lane_in_c.rem_im = si[PROD_W-1:0];
         lane_in_c.q_re = {lane_in.q_re[PROD_W-2:0], sr[PROD_W]};
         lane_in_c.q_im = {lane_in.q_im[PROD_W-2:0], si[PROD_W]};
         // Quotient bits pushed out of the top mean the result saturates.
         lane_in_c.sat_re = lane_in.sat_re | lane_in.q_re[PROD_W-1];
         lane_in_c.sat_im = lane_in.sat_im | lane_in.q_im[PROD_W-1];
      end else if (lane_in.func == FUNC_MAG && STEP >= TOTAL - 32) begin
         // Digit-by-digit root, one bit per cell over the last 32 cells.
         bitv = 64'd1 << (2 * (TOTAL - 1 - STEP));
         trial = lane_in.q_re + bitv;
         if (lane_in.rem_re >= trial) begin
            lane_in_c.rem_re = lane_in.rem_re - trial;
            lane_in_c.q_re = (lane_in.q_re >> 1) + bitv;
         end else begin
            lane_in_c.q_re = lane_in.q_re >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else begin
         lane_ff.valid <= lane_in.valid;
      end
      lane_ff.func   <= lane_in_c.func;
      lane_ff.dz     <= lane_in_c.dz;
      lane_ff.neg_re <= lane_in_c.neg_re;
      lane_ff.neg_im <= lane_in_c.neg_im;
      lane_ff.sat_re <= lane_in_c.sat_re;
      lane_ff.sat_im <= lane_in_c.sat_im;
      lane_ff.rem_re <= lane_in_c.rem_re;
      lane_ff.rem_im <= lane_in_c.rem_im;
      lane_ff.den    <= lane_in_c.den;
      lane_ff.q_re   <= lane_in_c.q_re;
      lane_ff.q_im   <= lane_in_c.q_im;
      lane_ff.pre_re <= lane_in_c.pre_re;
      lane_ff.pre_im <= lane_in_c.pre_im;
      lane_ff.pre_ovf <= lane_in_c.pre_ovf;
   end

   assign lane_out = lane_ff;

endmodule

/* sv/cau_front.sv */
// Front end: registers operands, forms the four cross products and the
// add/sub/mul results, and loads the first cell. Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req,
   output lane_type lane_out
);

   localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (DATA_WIDTH - 1);

   req_type req_ff;
   logic    vld_ff, vld2_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [PROD_W-1:0] p_aa_ff, p_qq_ff;
   logic [2:0] func2_ff;
   logic signed [PROD_W-1:0] s_re_ff, s_im_ff;

   lane_type lane_in;
   logic [PROD_W-1:0] n_re, n_im, den, m_re, m_im;
   logic neg_re, neg_im, o_re, o_im;
   logic signed [FIELD_W-1:0] v_re, v_im;

   function automatic logic [FIELD_W:0] pack(input logic neg,
                                             input logic [PROD_W-1:0] mag);
      logic [PROD_W-1:0] m;
      logic ovf;
      m = mag;
      ovf = 1'b0;
      if (!neg && mag > LIM - 1) begin
         m = LIM - 1;
         ovf = 1'b1;
      end else if (neg && mag > LIM) begin
         m = LIM;
         ovf = 1'b1;
      end
      if (neg) m = -m;
      pack = {ovf, m[FIELD_W-1:0]};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld_ff  <= start;
         vld2_ff <= vld_ff;
      end
      req_ff  <= req;
      func2_ff <= req_ff.func;
      p_rr_ff <= PROD_W'(req_ff.a_re) * PROD_W'(req_ff.b_re);
      p_ii_ff <= PROD_W'(req_ff.a_im) * PROD_W'(req_ff.b_im);
      p_ri_ff <= PROD_W'(req_ff.a_re) * PROD_W'(req_ff.b_im);
      p_ir_ff <= PROD_W'(req_ff.a_im) * PROD_W'(req_ff.b_re);
      p_bb_ff <= PROD_W'(req_ff.b_re) * PROD_W'(req_ff.b_re);
      p_cc_ff <= PROD_W'(req_ff.b_im) * PROD_W'(req_ff.b_im);
      p_aa_ff <= PROD_W'(req_ff.a_re) * PROD_W'(req_ff.a_re);
      p_qq_ff <= PROD_W'(req_ff.a_im) * PROD_W'(req_ff.a_im);
      s_re_ff <= (req_ff.func == FUNC_SUB) ?
                 PROD_W'(req_ff.a_re) - PROD_W'(req_ff.b_re) :
                 PROD_W'(req_ff.a_re) + PROD_W'(req_ff.b_re);
      s_im_ff <= (req_ff.func == FUNC_SUB) ?
                 PROD_W'(req_ff.a_im) - PROD_W'(req_ff.b_im) :
                 PROD_W'(req_ff.a_im) + PROD_W'(req_ff.b_im);
   end

   always_comb begin
      lane_in = '0;
      lane_in.valid = vld2_ff;
      lane_in.func  = func2_ff;
      n_re = '0;
      n_im = '0;
      den  = p_bb_ff + p_cc_ff;
      unique case (func2_ff)
         FUNC_MUL: begin
            n_re = p_rr_ff - p_ii_ff;
            n_im = p_ri_ff + p_ir_ff;
         end
         FUNC_DIV: begin
            n_re = p_rr_ff + p_ii_ff;
            n_im = p_ir_ff - p_ri_ff;
         end
         FUNC_MAG: n_re = p_aa_ff + p_qq_ff;
         default: begin
            n_re = s_re_ff;
            n_im = s_im_ff;
         end
      endcase
      // Sums that wrap past 2^63 are negative; exactly 2^63 stays positive.
      neg_re = (func2_ff == FUNC_MAG) ? 1'b0 : (n_re > 64'h8000_0000_0000_0000);
      neg_im = n_im > 64'h8000_0000_0000_0000;
      if (func2_ff == FUNC_ADD || func2_ff == FUNC_SUB) begin
         neg_re = n_re[PROD_W-1];
         neg_im = n_im[PROD_W-1];
      end
      m_re = neg_re ? -n_re : n_re;
      m_im = neg_im ? -n_im : n_im;
      {o_re, v_re} = pack(neg_re, (func2_ff == FUNC_MUL) ? m_re >> FRAC_BITS : m_re);
      {o_im, v_im} = pack(neg_im, (func2_ff == FUNC_MUL) ? m_im >> FRAC_BITS : m_im);
      lane_in.neg_re = neg_re;
      lane_in.neg_im = neg_im;
      lane_in.den    = den;
      lane_in.dz     = (func2_ff == FUNC_DIV) && (den == '0);
      lane_in.rem_re = m_re;
      lane_in.rem_im = m_im;
      if (func2_ff == FUNC_ADD || func2_ff == FUNC_SUB || func2_ff == FUNC_MUL) begin
         lane_in.pre_re  = v_re;
         lane_in.pre_im  = v_im;
         lane_in.pre_ovf = o_re | o_im;
      end
   end

   assign lane_out = lane_in;

endmodule

/* sv/cau_back.sv */
// Back end: scales and saturates the chain's quotients, saturates its roots,
// passes the add/sub/mul results through, and registers the result strobe. Depends on cau_pkg.
module cau_back import cau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  lane_type lane_in,
   output logic     done,
   output rsp_type  rsp
);

   localparam logic [PROD_W-1:0] LIM = PROD_W'(1) << (DATA_WIDTH - 1);
   localparam int   DROP = 32 - FRAC_BITS;

   rsp_type rsp_ff, rsp_in;
   logic    done_ff;
   logic [PROD_W-1:0] qr, qi;

   function automatic logic [FIELD_W:0] pack(input logic neg,
                                             input logic [PROD_W-1:0] mag);
      logic [PROD_W-1:0] m;
      logic ovf;
      m = mag;
      ovf = 1'b0;
      if (!neg && mag > LIM - 1) begin
         m = LIM - 1;
         ovf = 1'b1;
      end else if (neg && mag > LIM) begin
         m = LIM;
         ovf = 1'b1;
      end
      if (neg) m = -m;
      pack = {ovf, m[FIELD_W-1:0]};
   endfunction

   always_comb begin
      logic o1, o2;
      rsp_in = '0;
      o1 = 1'b0;
      o2 = 1'b0;
      // The chain computed trunc(num * 2^32 / den); drop the extra bits.
      qr = lane_in.q_re >> DROP;
      qi = lane_in.q_im >> DROP;
      unique case (lane_in.func)
         FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
            rsp_in.res_re   = lane_in.pre_re;
            rsp_in.res_im   = lane_in.pre_im;
            rsp_in.overflow = lane_in.pre_ovf;
         end
         FUNC_DIV: begin
            if (lane_in.dz) begin
               rsp_in.div_by_zero = 1'b1;
            end else begin
               {o1, rsp_in.res_re} = pack(lane_in.neg_re,
                  (lane_in.sat_re || lane_in.q_re[PROD_W-1 -: DROP] != '0) ?
                  LIM + 1 : qr);
               {o2, rsp_in.res_im} = pack(lane_in.neg_im,
                  (lane_in.sat_im || lane_in.q_im[PROD_W-1 -: DROP] != '0) ?
                  LIM + 1 : qi);
               rsp_in.overflow = o1 | o2;
            end
         end
         FUNC_MAG: begin
            {o1, rsp_in.res_re} = pack(1'b0, lane_in.q_re);
            rsp_in.overflow = o1;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= lane_in.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign done = done_ff;
   assign rsp  = rsp_ff;

endmodule

/* sv/complex_arith_unit_core.sv */
// Complex arithmetic unit in signed fixed point: add, subtract, multiply,
// divide, magnitude. One transfer is taken every cycle (busy stays low) and
// each result appears with rsp_valid after passing through two front stages
// (operand and product registers), a chain of 96 one-bit quotient/root
// cells, and an output register. The receiver cannot stall, so results must
// be taken.
module complex_arith_unit_core import cau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CELLS = 96;

   lane_type lane [CELLS+1];

   cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .start(start), .req(req_data),
      .lane_out(lane[0]));

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      cau_cell #(.STEP(g)) u_cell (
         .clock(clock), .reset(reset), .lane_in(lane[g]), .lane_out(lane[g+1]));
   end

   cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .lane_in(lane[CELLS]),
      .done(rsp_valid), .rsp(rsp_data));

   assign busy = 1'b0;

endmodule
